### sv/assert_macros.svh
// Assertion macros shared by the keypad and LCD port RTL; clk and rst_n come from the caller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle while reset is asserted
`define KLP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, idle while reset is asserted
`define KLP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### sv/klp_pkg.sv
// Constants, codes and structs of the keypad and LCD I/O port.
package klp_pkg;

    // Key queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Key hold timing
    localparam logic [4:0] POP_GAP    = 5'd24;
    localparam logic [4:0] HOLD_READS = 5'd16;
    localparam logic [4:0] HOLD_MAX   = 5'd31;

    // Bus map
    localparam logic [15:0] KEYPAD_LO  = 16'h2C00;
    localparam logic [15:0] KEYPAD_HI  = 16'h2C07;
    localparam logic [15:0] FLAG_LO    = 16'h3400;
    localparam logic [15:0] FLAG_HI    = 16'h3407;
    localparam logic [15:0] DIGIT_ADDR = 16'h2000;

    // Read answers
    localparam logic [7:0] KEY_HIT_DATA = 8'h7F;
    localparam logic [7:0] IDLE_DATA    = 8'hFF;

    localparam int NUM_DIGITS = 4;
    localparam int LED_W      = 6;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_KEY   = 2'd2
    } klp_mode_t;

    // Top level to key queue
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] key_in;
    } klp_fifo_ctrl_t;

    // Key queue to top level
    typedef struct packed {
        logic       empty;
        logic       full;
        logic [7:0] head_key;
    } klp_fifo_stat_t;

    // One result word
    typedef struct packed {
        logic [7:0]       read_data;
        logic [7:0]       digit0;
        logic [7:0]       digit1;
        logic [7:0]       digit2;
        logic [7:0]       digit3;
        logic [LED_W-1:0] led_flags;
        logic             display_changed;
        logic             key_dropped;
    } klp_res_t;

endpackage

### sv/klp_if.sv
// Valid/ready channel interfaces for request and result words.
interface klp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  key_code;

    modport source (output valid, output mode, output address, output write_data,
                    output key_code, input ready);
    modport sink (input valid, input mode, input address, input write_data,
                  input key_code, output ready);
endinterface

interface klp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [7:0] digit0;
    logic [7:0] digit1;
    logic [7:0] digit2;
    logic [7:0] digit3;
    logic [5:0] led_flags;
    logic       display_changed;
    logic       key_dropped;

    modport source (output valid, output read_data, output digit0, output digit1,
                    output digit2, output digit3, output led_flags,
                    output display_changed, output key_dropped, input ready);
    modport sink (input valid, input read_data, input digit0, input digit1,
                  input digit2, input digit3, input led_flags,
                  input display_changed, input key_dropped, output ready);
endinterface

### sv/keypad_lcd_io_port_unit.sv
// Keypad and LCD I/O port: bus decode, display latches, key hold timer and output skid.
// Results go to the output register, or to the skid register while the output stalls.
// Throughput: one word per cycle while ready; the queue RAM prefetches the head word.
// Ready falls only when the result register and the skid register both hold words.
// Reset clears flags, latches, display, pointers and the queue fill count; the hold
// timer resets to the pop gap so the first read may pop a queued key.
`include "assert_macros.svh"
module keypad_lcd_io_port_unit import klp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    klp_in_if.sink    cmd,
    klp_out_if.source rsp
);

    logic [7:0]       flag_reg,   flag_next;
    logic [7:0]       latch_reg  [NUM_DIGITS];
    logic [7:0]       latch_next [NUM_DIGITS];
    logic [7:0]       shown_reg  [NUM_DIGITS];
    logic [7:0]       shown_next [NUM_DIGITS];
    logic [7:0]       last_dig_reg  [NUM_DIGITS];
    logic [7:0]       last_dig_next [NUM_DIGITS];
    logic [LED_W-1:0] last_flags_reg, last_flags_next;
    logic [1:0]       ptr_reg, ptr_next;
    logic [7:0]       held_reg, held_next;
    logic             held_valid_reg, held_valid_next;
    logic [4:0]       hold_cnt_reg, hold_cnt_next;

    logic             acc;
    logic             pop_try;
    logic             in_keypad;
    logic             in_flags;
    logic             changed;
    klp_res_t         res;
    klp_res_t         out_reg, out_next;
    klp_res_t         skid_reg, skid_next;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;

    klp_fifo_ctrl_t   fifo_ctrl;
    klp_fifo_stat_t   fifo_stat;

    klp_key_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (fifo_ctrl),
        .stat  (fifo_stat)
    );

    assign cmd.ready = !skid_valid_reg;
    assign acc       = cmd.valid && cmd.ready;
    assign pop_try   = !held_valid_reg && (hold_cnt_reg >= POP_GAP);
    assign in_keypad = (cmd.address >= KEYPAD_LO) && (cmd.address <= KEYPAD_HI);
    assign in_flags  = (cmd.address >= FLAG_LO) && (cmd.address <= FLAG_HI);

    // Item processing
    always_comb
    begin
        flag_next       = flag_reg;
        latch_next      = latch_reg;
        shown_next      = shown_reg;
        last_dig_next   = last_dig_reg;
        last_flags_next = last_flags_reg;
        ptr_next        = ptr_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        hold_cnt_next   = hold_cnt_reg;
        changed         = 1'b0;
        res             = '0;
        res.read_data   = IDLE_DATA;
        fifo_ctrl       = '0;
        fifo_ctrl.key_in = cmd.key_code;

        if (acc)
        begin
            case (cmd.mode)
                MODE_READ:
                begin
                    // pop attempt on any read
                    if (pop_try)
                    begin
                        if (!fifo_stat.empty)
                        begin
                            held_next       = fifo_stat.head_key;
                            held_valid_next = 1'b1;
                            hold_cnt_next   = '0;
                            fifo_ctrl.pop   = 1'b1;
                        end
                        else
                        begin
                            hold_cnt_next = POP_GAP;
                        end
                    end
                    // key matrix scan
                    if (in_keypad)
                    begin
                        if (held_valid_next && (held_next[7] == flag_reg[7]) &&
                            (held_next[3:0] == cmd.address[3:0]))
                        begin
                            res.read_data = KEY_HIT_DATA;
                            if (hold_cnt_next >= HOLD_READS)
                            begin
                                held_valid_next = 1'b0;
                                hold_cnt_next   = '0;
                            end
                        end
                        if (hold_cnt_next < HOLD_MAX)
                        begin
                            hold_cnt_next = hold_cnt_next + 1'b1;
                        end
                    end
                end
                MODE_WRITE:
                begin
                    if (in_flags)
                    begin
                        flag_next[cmd.address[2:0]] = cmd.write_data[7];
                        if (cmd.address == FLAG_HI)
                        begin
                            for (int i = 0; i < NUM_DIGITS; i++)
                            begin
                                shown_next[i] = latch_reg[i] ^ {8{flag_next[7]}};
                            end
                        end
                    end
                    else if (cmd.address == DIGIT_ADDR)
                    begin
                        latch_next[ptr_reg] = cmd.write_data;
                        ptr_next            = ptr_reg - 1'b1;
                    end
                    // change report against last reported view
                    if ((flag_next[LED_W-1:0] != last_flags_reg) ||
                        (shown_next != last_dig_reg))
                    begin
                        changed         = 1'b1;
                        last_flags_next = flag_next[LED_W-1:0];
                        last_dig_next   = shown_next;
                    end
                end
                MODE_KEY:
                begin
                    fifo_ctrl.push  = !fifo_stat.full;
                    res.key_dropped = fifo_stat.full;
                end
                default:
                begin
                end
            endcase
        end

        res.digit0          = shown_next[0];
        res.digit1          = shown_next[1];
        res.digit2          = shown_next[2];
        res.digit3          = shown_next[3];
        res.led_flags       = flag_next[LED_W-1:0];
        res.display_changed = changed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg       <= '0;
            latch_reg      <= '{default: '0};
            shown_reg      <= '{default: '0};
            last_dig_reg   <= '{default: '0};
            last_flags_reg <= '0;
            ptr_reg        <= '0;
            held_valid_reg <= 1'b0;
            hold_cnt_reg   <= POP_GAP;
        end
        else
        begin
            flag_reg       <= flag_next;
            latch_reg      <= latch_next;
            shown_reg      <= shown_next;
            last_dig_reg   <= last_dig_next;
            last_flags_reg <= last_flags_next;
            ptr_reg        <= ptr_next;
            held_valid_reg <= held_valid_next;
            hold_cnt_reg   <= hold_cnt_next;
        end
    end

    // held key payload, meaningful only while valid
    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

    // Output register with skid stage
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_valid_reg && !rsp.ready)
        begin
            if (acc)
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_next        = skid_reg;
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_next       = res;
            out_valid_next = acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.read_data       = out_reg.read_data;
    assign rsp.digit0          = out_reg.digit0;
    assign rsp.digit1          = out_reg.digit1;
    assign rsp.digit2          = out_reg.digit2;
    assign rsp.digit3          = out_reg.digit3;
    assign rsp.led_flags       = out_reg.led_flags;
    assign rsp.display_changed = out_reg.display_changed;
    assign rsp.key_dropped     = out_reg.key_dropped;

    `KLP_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `KLP_ASSERT_IMP(a_pop_when_free, fifo_ctrl.pop, !held_valid_reg && hold_cnt_reg >= POP_GAP)
    `KLP_ASSERT_NXT(a_report_on_write, acc && cmd.mode != MODE_WRITE, $stable(last_flags_reg))

endmodule

### sv/klp_key_fifo.sv
// Key queue: circular buffer in a synchronous RAM with a prefetched head word.
`include "assert_macros.svh"
module klp_key_fifo import klp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  klp_fifo_ctrl_t ctrl,
    output klp_fifo_stat_t stat
);

    logic [7:0]        mem [QUEUE_DEPTH];
    logic [7:0]        head_data_reg;
    logic [QPTR_W-1:0] head_reg;
    logic [QPTR_W-1:0] head_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic [QPTR_W-1:0] tail;
    logic [QCNT_W:0]   tail_sum;
    logic              fwd;

    // Tail slot, wrapped once
    always_comb
    begin
        tail_sum = {1'b0, {(QCNT_W - QPTR_W){1'b0}}, head_reg} + {1'b0, count_reg};
        if (tail_sum >= (QCNT_W + 1)'(QUEUE_DEPTH))
        begin
            tail_sum = tail_sum - (QCNT_W + 1)'(QUEUE_DEPTH);
        end
        tail = tail_sum[QPTR_W-1:0];
    end

    // Pointer and fill count
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctrl.pop)
        begin
            head_next  = (head_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (ctrl.push)
        begin
            count_next = count_next + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // RAM: one write, one registered read of the next head; bypass a write to that slot
    assign fwd = ctrl.push && (tail == head_next);

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail] <= ctrl.key_in;
        end
        head_data_reg <= fwd ? ctrl.key_in : mem[head_next];
    end

    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.head_key = head_data_reg;

    `KLP_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `KLP_ASSERT_IMP(a_no_push_full, ctrl.push, !stat.full)
    `KLP_ASSERT_IMP(a_no_pop_empty, ctrl.pop, !stat.empty)
    `KLP_ASSERT_NXT(a_push_counts, ctrl.push && !ctrl.pop, count_reg == $past(count_reg) + 1'b1)

endmodule
